// File: rtl/core/fixed_point_alu_core_assert.svh
// Assertion macros used by the checker.
`ifndef FIXED_POINT_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_ALU_CORE_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Next-cycle implication, quiet while reset is asserted.
`define FPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: rtl/core/fpa_pkg.sv
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_W       = 32;
	localparam int MODE_W        = 4;

	typedef enum logic [MODE_W-1:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

endpackage

// File: rtl/core/fpa_if.sv
interface fpa_req_if;
	logic                                valid;
	logic                                ready;
	logic [fpa_pkg::MODE_W-1:0]          mode;
	logic signed [fpa_pkg::FIELD_W-1:0]  operand_a;
	logic signed [fpa_pkg::FIELD_W-1:0]  operand_b;

	modport source (output valid, mode, operand_a, operand_b, input ready);
	modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [fpa_pkg::FIELD_W-1:0]  value;
	logic                                flag;
	logic                                status;

	modport source (output valid, value, flag, status, input ready);
	modport sink   (input valid, value, flag, status, output ready);
endinterface

// File: rtl/core/fixed_point_alu_core.sv
// Path: an accepted beat is registered in stage 1, then passes the one-bit-per-stage
//   divider (dividend capped at 64 bits) or the ALU path, then the output register.
// Throughput: one beat per cycle; a stall on the result side freezes the whole pipe.
// Reset: arst_n clears all valid bits asynchronously; datapath registers are not reset.
module fixed_point_alu_core #(
	parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	fpa_req_if.sink  req,
	fpa_rsp_if.source rsp
);
	import fpa_pkg::*;

	// divider dividend width: shifted operand, wrapped at 64 bits
	localparam int DW      = (WORD_BITS + FRAC_BITS > 64) ? 64 : WORD_BITS + FRAC_BITS;
	localparam int LAT     = DW + 2;
	localparam int ALU_DLY = DW - 2;

	logic en;

	// input operands wrapped to the working word
	logic signed [63:0]          a_ext, b_ext, aw64, n64, nmag;
	logic [WORD_BITS-1:0]        aw, bw, bmag;

	// stage 1
	op_t                         mode_s1;
	logic signed [WORD_BITS-1:0] a_s1, b_s1;
	logic [DW-1:0]               num_s1;
	logic [WORD_BITS-1:0]        den_s1;
	logic                        neg_s1, dz_s1;

	logic [LAT-1:0] vld_q;

	logic signed [WORD_BITS-1:0] alu_val;
	logic                        alu_flag, alu_div;

	logic signed [WORD_BITS-1:0] dly_val  [ALU_DLY];
	logic                        dly_flag [ALU_DLY];
	logic                        dly_div  [ALU_DLY];

	logic [DW-1:0]               quo;
	logic                        q_neg, q_dz;
	logic [WORD_BITS-1:0]        qw, qs;
	logic signed [WORD_BITS-1:0] v;

	logic signed [FIELD_W-1:0] value_q;
	logic                      flag_q, status_q;

	// whole pipe advances unless a finished beat is held at the output
	assign en        = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = en;

	assign a_ext = 64'(req.operand_a);
	assign b_ext = 64'(req.operand_b);
	assign aw    = a_ext[WORD_BITS-1:0];
	assign bw    = b_ext[WORD_BITS-1:0];
	assign aw64  = 64'($signed(aw));
	assign n64   = aw64 << FRAC_BITS;
	assign nmag  = n64[63] ? -n64 : n64;
	assign bmag  = bw[WORD_BITS-1] ? -bw : bw;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= op_t'(req.mode);
			a_s1    <= aw;
			b_s1    <= bw;
			num_s1  <= nmag[DW-1:0];
			den_s1  <= bmag;
			neg_s1  <= n64[63] ^ bw[WORD_BITS-1];
			dz_s1   <= (bw == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	fpa_alu #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.en     (en),
		.mode   (mode_s1),
		.a      (a_s1),
		.b      (b_s1),
		.value  (alu_val),
		.flag   (alu_flag),
		.is_div (alu_div)
	);

	fpa_div #(
		.WORD_BITS (WORD_BITS),
		.DW        (DW)
	) u_div (
		.clk   (clk),
		.en    (en),
		.num   (num_s1),
		.den   (den_s1),
		.neg   (neg_s1),
		.dz    (dz_s1),
		.quo   (quo),
		.neg_o (q_neg),
		.dz_o  (q_dz)
	);

	// align the short ALU path with the divider
	always_ff @(posedge clk) begin
		if (en) begin
			dly_val[0]  <= alu_val;
			dly_flag[0] <= alu_flag;
			dly_div[0]  <= alu_div;
			for (int i = 1; i < ALU_DLY; i++) begin
				dly_val[i]  <= dly_val[i-1];
				dly_flag[i] <= dly_flag[i-1];
				dly_div[i]  <= dly_div[i-1];
			end
		end
	end

	// quotient sign fix-up and final select
	assign qw = quo[WORD_BITS-1:0];
	assign qs = q_neg ? -qw : qw;

	always_comb begin
		if (dly_div[ALU_DLY-1]) begin
			v = q_dz ? '0 : qs;
		end else begin
			v = dly_val[ALU_DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= FIELD_W'(v);
			flag_q   <= dly_flag[ALU_DLY-1];
			status_q <= dly_div[ALU_DLY-1] && q_dz;
		end
	end

	assign rsp.valid  = vld_q[LAT-1];
	assign rsp.value  = value_q;
	assign rsp.flag   = flag_q;
	assign rsp.status = status_q;
endmodule

// File: rtl/core/fpa_div.sv
// Restoring divider, one quotient bit per stage, magnitudes only.
module fpa_div #(
	parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
	parameter int DW        = fpa_pkg::WORD_BITS_DEF + fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DW-1:0]        num,
	input  logic [WORD_BITS-1:0] den,
	input  logic                 neg,
	input  logic                 dz,
	output logic [DW-1:0]        quo,
	output logic                 neg_o,
	output logic                 dz_o
);
	import fpa_pkg::*;

	logic [WORD_BITS-1:0] rem_s [1:DW];
	logic [DW-1:0]        nq_s  [1:DW];
	logic [WORD_BITS-1:0] den_s [1:DW];
	logic                 neg_s [1:DW];
	logic                 dz_s  [1:DW];

	for (genvar i = 0; i < DW; i++) begin : g_step
		logic [WORD_BITS-1:0] rem_p;
		logic [DW-1:0]        nq_p;
		logic [WORD_BITS-1:0] den_p;
		logic                 neg_p;
		logic                 dz_p;
		logic [WORD_BITS:0]   trial;
		logic [WORD_BITS:0]   diff;
		logic                 ge;

		if (i == 0) begin : g_first
			assign rem_p = '0;
			assign nq_p  = num;
			assign den_p = den;
			assign neg_p = neg;
			assign dz_p  = dz;
		end else begin : g_next
			assign rem_p = rem_s[i];
			assign nq_p  = nq_s[i];
			assign den_p = den_s[i];
			assign neg_p = neg_s[i];
			assign dz_p  = dz_s[i];
		end

		assign trial = {rem_p, nq_p[DW-1]};
		assign diff  = trial - {1'b0, den_p};
		assign ge    = (trial >= {1'b0, den_p});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
				nq_s[i+1]  <= {nq_p[DW-2:0], ge};
				den_s[i+1] <= den_p;
				neg_s[i+1] <= neg_p;
				dz_s[i+1]  <= dz_p;
			end
		end
	end

	assign quo   = nq_s[DW];
	assign neg_o = neg_s[DW];
	assign dz_o  = dz_s[DW];
endmodule

// File: rtl/core/fpa_alu.sv
// Non-divide operations: two stages, products split into 32-bit pieces.
module fpa_alu #(
	parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  fpa_pkg::op_t                mode,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic signed [WORD_BITS-1:0] value,
	output logic                        flag,
	output logic                        is_div
);
	import fpa_pkg::*;

	localparam logic [WORD_BITS:0] RND =
		(WORD_BITS+1)'((64'd1 << FRAC_BITS) - 64'd1);

	logic signed [63:0]        a64, b64;
	logic                      lt, gt, eq;
	logic signed [WORD_BITS:0] ti_sum, ti_shr;
	logic [WORD_BITS-1:0]      res;
	logic                      flg;

	logic [WORD_BITS-1:0] res_s1;
	logic                 flag_s1;
	op_t                  mode_s1;
	logic [63:0]          p_ll_s1;
	logic [31:0]          p_hl_s1, p_lh_s1;

	logic [63:0]        p64;
	logic signed [63:0] prod;

	assign a64 = 64'(a);
	assign b64 = 64'(b);
	assign lt  = (a < b);
	assign gt  = (b < a);
	assign eq  = (a == b);

	// to_int: bias negatives so the arithmetic shift truncates toward zero
	assign ti_sum = {a[WORD_BITS-1], a} + (a[WORD_BITS-1] ? RND : '0);
	assign ti_shr = ti_sum >>> FRAC_BITS;

	always_comb begin
		res = '0;
		flg = 1'b0;
		unique case (mode)
			OP_ADD:      res = a + b;
			OP_SUB:      res = a - b;
			OP_MUL:      res = '0;
			OP_DIV:      res = '0;
			OP_GT:       flg = gt;
			OP_LT:       flg = lt;
			OP_GE:       flg = !lt;
			OP_LE:       flg = !gt;
			OP_EQ:       flg = eq;
			OP_NE:       flg = !eq;
			OP_MIN:      res = lt ? a : b;
			OP_MAX:      res = gt ? a : b;
			OP_INC:      res = a + WORD_BITS'(1);
			OP_DEC:      res = a - WORD_BITS'(1);
			OP_FROM_INT: res = a << FRAC_BITS;
			OP_TO_INT:   res = ti_shr[WORD_BITS-1:0];
			default:     res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1  <= res;
			flag_s1 <= flg;
			mode_s1 <= mode;
			p_ll_s1 <= a64[31:0] * b64[31:0];
			p_hl_s1 <= a64[63:32] * b64[31:0];
			p_lh_s1 <= a64[31:0] * b64[63:32];
		end
	end

	// low 64 bits of the signed product, then arithmetic shift
	assign p64  = p_ll_s1 + {p_hl_s1 + p_lh_s1, 32'b0};
	assign prod = $signed(p64) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			value  <= (mode_s1 == OP_MUL) ? prod[WORD_BITS-1:0] : res_s1;
			flag   <= flag_s1;
			is_div <= (mode_s1 == OP_DIV);
		end
	end
endmodule

// File: rtl/core/fpa_checker.sv
`include "fixed_point_alu_core_assert.svh"

module fpa_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [fpa_pkg::FIELD_W-1:0] rsp_value,
	input logic                               rsp_flag,
	input logic                               rsp_status
);
	import fpa_pkg::*;

	`FPA_ASSERT_IMP(a_dz_no_flag, clk, arst_n, rsp_valid && rsp_status, !rsp_flag)
	`FPA_ASSERT_IMP(a_dz_zero, clk, arst_n, rsp_valid && rsp_status, rsp_value == '0)
	`FPA_ASSERT_IMP(a_cmp_zero, clk, arst_n, rsp_valid && rsp_flag, rsp_value == '0)
	`FPA_ASSERT_IMP(a_busy_only_stalled, clk, arst_n, !req_ready, rsp_valid && !rsp_ready)
	`FPA_ASSERT_NXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value),
	.rsp_flag   (rsp.flag),
	.rsp_status (rsp.status)
);
